// ===== rtl/core/ordered_key_value_table_top_macros.svh =====
// Assertion macros for the ordered key/value table RTL.
// No dependencies; included inside module bodies that check their own logic.
`ifndef ORDERED_KEY_VALUE_TABLE_TOP_MACROS_SVH
`define ORDERED_KEY_VALUE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define OKVT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("okvt: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define OKVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("okvt: next-cycle check failed");

`endif

// ===== rtl/core/okvt_pkg.sv =====
// Types and codes for the ordered key/value table.
// No dependencies; imported by okvt_cell and ordered_key_value_table_top.
package okvt_pkg;

   localparam int unsigned FUNC_W  = 3;
   localparam int unsigned KEY_W   = 32;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned POS_W   = 4;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT   = 3'd0,
      FUNC_UPDATE   = 3'd1,
      FUNC_UPSERT   = 3'd2,
      FUNC_ERASE    = 3'd3,
      FUNC_LOOKUP   = 3'd4,
      FUNC_READ_POS = 3'd5
   } okvt_func_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_APPLY = 1'b1
   } okvt_state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;
   } okvt_req_type;

   typedef struct packed {
      logic               ok;
      logic [KEY_W-1:0]   out_key;
      logic [VALUE_W-1:0] out_value;
      logic [COUNT_W-1:0] entry_count;
      logic               full_flag;
   } okvt_rsp_type;

   // Per-cell write controls for the apply cycle.
   typedef struct packed {
      logic erase;       // close the gap at and above the matching cell
      logic load_new;    // take the new key and value (append here)
      logic update;      // take the new value if this cell matched
   } okvt_cell_ctl_type;

endpackage

// ===== rtl/core/ordered_key_value_table_top.sv =====
// Ordered key/value table: the request/response shell and the row of entry cells.
// Depends on okvt_pkg, okvt_cell and ordered_key_value_table_top_macros.svh.
//
// Use: a word on req_ (func, key, value, position) is one operation: insert,
// update, insert-or-update, erase, lookup by key or read by position. Each
// word gives exactly one rsp_ word with ok, out_key, out_value, the entry
// count after the operation and the full flag of a refused insert.
// Both channels are valid/ready; a word moves when valid and ready are high.
// Flow: an accepted word is compared against every occupied cell at the
// accept edge; the next edge applies the write and loads the response
// register, which raises rsp_valid. Each request passes a compare step
// and then an apply step through the cell row, and no new request is
// taken during the apply step. req_ready is low during the apply step
// and while a response waits that is not taken in the same cycle.
// Reset (synchronous, active high) empties the table and drops any pending
// response; cell contents are not cleared, only the count.
// A stalled receiver holds rsp_data steady and backs up into req_ready.
module ordered_key_value_table_top #(
   parameter int unsigned CAPACITY   = 16,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  okvt_pkg::okvt_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output okvt_pkg::okvt_rsp_type rsp_data
);
   import okvt_pkg::*;
   `include "ordered_key_value_table_top_macros.svh"

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   okvt_state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   okvt_rsp_type   rsp_ff, rsp_in;
   okvt_req_type   op_ff;
   logic           accept, apply;

   logic [KEY_BITS+KEY_W-1:0]     cmp_ext, op_key_ext;
   logic [VALUE_BITS+VALUE_W-1:0] op_value_ext;
   logic [KEY_BITS-1:0]           cmp_key, op_key;
   logic [VALUE_BITS-1:0]         op_value;

   logic [CAPACITY-1:0]   occupied, append_sel, pos_sel, match_vec;
   logic [CAPACITY:0]     chain;
   logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
   logic [VALUE_BITS-1:0] cell_value [CAPACITY];
   okvt_cell_ctl_type     cell_ctl   [CAPACITY];

   logic                  hit, full, pos_ok;
   logic                  do_erase, do_append, do_update;
   logic [KEY_BITS-1:0]   read_key, okey;
   logic [VALUE_BITS-1:0] read_value, lookup_value, oval;
   logic                  ok, full_flag;
   logic [KEY_BITS+KEY_W-1:0]     okey_ext;
   logic [VALUE_BITS+VALUE_W-1:0] oval_ext;
   logic [CW+COUNT_W-1:0]         count_ext;

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      apply     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            apply    = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = apply ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_data;
      end
      if (apply) begin
         rsp_ff <= rsp_in;
      end
   end

   // Trim or widen port keys and values to the stored widths.
   assign cmp_ext      = {{KEY_BITS{1'b0}}, req_data.key};
   assign cmp_key      = cmp_ext[KEY_BITS-1:0];
   assign op_key_ext   = {{KEY_BITS{1'b0}}, op_ff.key};
   assign op_key       = op_key_ext[KEY_BITS-1:0];
   assign op_value_ext = {{VALUE_BITS{1'b0}}, op_ff.value};
   assign op_value     = op_value_ext[VALUE_BITS-1:0];

   // ---------------------------------------------------------------- cell row
   assign chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0]   nxt_key;
      logic [VALUE_BITS-1:0] nxt_value;

      assign occupied[i]   = CW'(i) < count_ff;
      assign append_sel[i] = CW'(i) == count_ff;
      assign pos_sel[i]    = occupied[i] && (32'(op_ff.position) == 32'(i));

      assign cell_ctl[i].erase    = do_erase;
      assign cell_ctl[i].load_new = do_append && append_sel[i];
      assign cell_ctl[i].update   = do_update;

      if (i < CAPACITY - 1) begin : g_mid
         assign nxt_key   = cell_key[i+1];
         assign nxt_value = cell_value[i+1];
      end else begin : g_last
         assign nxt_key   = cell_key[i];
         assign nxt_value = cell_value[i];
      end

      okvt_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock      (clock),
         .cmp_en     (accept),
         .cmp_key    (cmp_key),
         .occupied   (occupied[i]),
         .ctl        (cell_ctl[i]),
         .new_key    (op_key),
         .new_value  (op_value),
         .next_key   (nxt_key),
         .next_value (nxt_value),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .match      (match_vec[i]),
         .key        (cell_key[i]),
         .value      (cell_value[i])
      );
   end

   // Keys are unique, so at most one cell matches: AND-OR select is enough.
   always_comb begin
      lookup_value = '0;
      read_key     = '0;
      read_value   = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_vec[i]) begin
            lookup_value = lookup_value | cell_value[i];
         end
         if (pos_sel[i]) begin
            read_key   = read_key | cell_key[i];
            read_value = read_value | cell_value[i];
         end
      end
   end

   // ---------------------------------------------------------------- apply
   assign hit    = chain[CAPACITY];
   assign full   = count_ff == CW'(CAPACITY);
   assign pos_ok = |pos_sel;

   always_comb begin
      do_erase  = 1'b0;
      do_append = 1'b0;
      do_update = 1'b0;
      ok        = 1'b0;
      full_flag = 1'b0;
      okey      = op_key;
      oval      = '0;
      count_in  = count_ff;
      case (okvt_func_type'(op_ff.func))
         FUNC_INSERT, FUNC_UPSERT: begin
            if (hit) begin
               if (okvt_func_type'(op_ff.func) == FUNC_UPSERT) begin
                  do_update = apply;
                  ok        = 1'b1;
               end
            end else if (full) begin
               full_flag = 1'b1;
            end else begin
               do_append = apply;
               ok        = 1'b1;
               if (apply) begin
                  count_in = count_ff + CW'(1);
               end
            end
         end
         FUNC_UPDATE: begin
            do_update = apply && hit;
            ok        = hit;
         end
         FUNC_ERASE: begin
            do_erase = apply && hit;
            ok       = hit;
            if (apply && hit) begin
               count_in = count_ff - CW'(1);
            end
         end
         FUNC_LOOKUP: begin
            ok   = hit;
            oval = lookup_value;
         end
         FUNC_READ_POS: begin
            ok = pos_ok;
            if (pos_ok) begin
               okey = read_key;
               oval = read_value;
            end
         end
         default: ok = 1'b0;
      endcase
   end

   assign okey_ext  = {{KEY_W{1'b0}}, okey};
   assign oval_ext  = {{VALUE_W{1'b0}}, oval};
   assign count_ext = {{COUNT_W{1'b0}}, count_in};

   always_comb begin
      rsp_in.ok          = ok;
      rsp_in.out_key     = okey_ext[KEY_W-1:0];
      rsp_in.out_value   = oval_ext[VALUE_W-1:0];
      rsp_in.entry_count = count_ext[COUNT_W-1:0];
      rsp_in.full_flag   = full_flag;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------- checks
   `OKVT_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `OKVT_ASSERT_IMPL(a_unique_match, clock, reset, state_ff == ST_APPLY, $onehot0(match_vec))
   `OKVT_ASSERT_NEXT(a_accept_applies, clock, reset, accept, state_ff == ST_APPLY)
   `OKVT_ASSERT_IMPL(a_rsp_from_apply, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_APPLY)
   `OKVT_ASSERT_IMPL(a_count_in_apply, clock, reset, !$stable(count_ff),
      $past(state_ff) == ST_APPLY)

endmodule

// ===== rtl/core/okvt_cell.sv =====
// One entry of the ordered key/value table: key, value and a registered match bit.
// Depends on okvt_pkg; chained by ordered_key_value_table_top.
module okvt_cell #(
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       cmp_en,
   input  logic [KEY_BITS-1:0]        cmp_key,
   input  logic                       occupied,
   input  okvt_pkg::okvt_cell_ctl_type ctl,
   input  logic [KEY_BITS-1:0]        new_key,
   input  logic [VALUE_BITS-1:0]      new_value,
   input  logic [KEY_BITS-1:0]        next_key,
   input  logic [VALUE_BITS-1:0]      next_value,
   input  logic                       chain_in,
   output logic                       chain_out,
   output logic                       match,
   output logic [KEY_BITS-1:0]        key,
   output logic [VALUE_BITS-1:0]      value
);
   import okvt_pkg::*;

   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  match_ff;
   logic                  shift;

   // On erase, a hit at or below this cell moves everything from here upward down by one.
   assign chain_out = chain_in | match_ff;
   assign shift     = ctl.erase & chain_out;

   always_ff @(posedge clock) begin
      if (cmp_en) begin
         match_ff <= occupied && (key_ff == cmp_key);
      end
      if (shift) begin
         key_ff   <= next_key;
         value_ff <= next_value;
      end else if (ctl.load_new) begin
         key_ff   <= new_key;
         value_ff <= new_value;
      end else if (ctl.update && match_ff) begin
         value_ff <= new_value;
      end
   end

   assign match = match_ff;
   assign key   = key_ff;
   assign value = value_ff;

endmodule
